// ----- hdl/spps_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spps_pkg
// Shared constants, codes and types of the stepper proportional position step
// controller.
// ----------------------------------------------------------------------------
package spps_pkg;

    // width of the shared multiplier operands
    localparam int MUL_W = 24;

    // default step counter width
    localparam int COUNT_WIDTH_DEF = 32;

    // enable pin polarity: 1 drives the pin low when enabled
    localparam logic ENABLE_ACTIVE_LOW = 1'b0;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEG_STEP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOME      = 3'd5;

    // configuration reset values
    localparam logic [15:0] KP_GAIN_RST   = 16'd256;
    localparam logic [15:0] TOLERANCE_RST = 16'd128;
    localparam logic [15:0] MIN_PER_RST   = 16'd500;
    localparam logic [15:0] MAX_PER_RST   = 16'd5000;
    localparam logic [23:0] DEG_STEP_RST  = 24'd117965;
    localparam logic [23:0] HOME_RST      = 24'd0;

    // item kinds
    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_TARGET = 2'd1,
        KIND_HOME   = 2'd2,
        KIND_ENABLE = 2'd3
    } kind_t;

    // clamped count magnitude: |count| <= 2^38
    localparam int CMAG_W = 39;
    // clamped error magnitude: |error| <= 2^40, Q.16
    localparam int EMAG_W = 41;
    localparam logic [62:0] ERR_CLAMP = 63'h0000_0100_0000_0000;
    // full control, 100 degrees in Q.24
    localparam int CTL_W = 31;
    localparam logic [62:0] FULL_CONTROL = 63'd1677721600;

    // ceil(x / 100) as floor((x + 99) * RECIP >> RECIP_SHIFT), exact for x < 2^23
    localparam logic [MUL_W-1:0] RECIP       = 24'd10737419;
    localparam int               RECIP_SHIFT = 30;
    localparam logic [MUL_W-1:0] HUNDRED_M1  = 24'd99;

endpackage
`default_nettype wire

// ----- hdl/spps_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spps_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module spps_mul (
    input  wire logic                         aclk,
    input  wire logic [spps_pkg::MUL_W-1:0]   a,
    input  wire logic [spps_pkg::MUL_W-1:0]   b,
    output logic      [2*spps_pkg::MUL_W-1:0] product
);

    always_ff @(posedge aclk) begin
        product <= a * b;
    end

endmodule
`default_nettype wire

// ----- hdl/stepper_proportional_position_step.sv -----
// A non-stepping item runs the position, error and decide states, then ST_FIN;
// a stepping tick also runs magnitude and period states and recomputes position
// and error. One item at a time: the next is taken no sooner than the cycle
// after the result is registered; ST_FIN waits while the output is held. A
// single 24x24 multiplier is used for every product in turn. Reset:
// synchronous, active low; clears count, target, sequencer and result valid.
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_proportional_position_step
// Proportional position controller for a stepper: one control step per tick,
// target, home and enable commands, step period from the control magnitude.
// ----------------------------------------------------------------------------
module stepper_proportional_position_step #(
    parameter int COUNT_WIDTH = spps_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [spps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [23:0]                      cfg_data,
    // input items
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_kind,
    input  wire logic signed [23:0]               s_target_angle,
    input  wire logic                             s_enable_value,
    // result items
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_step_pulse,
    output logic                                  m_direction_positive,
    output logic [15:0]                           m_pulse_interval_us,
    output logic                                  m_enable_pin,
    output logic signed [31:0]                    m_step_position,
    output logic signed [23:0]                    m_position_angle,
    output logic                                  m_at_target
);

    localparam int MW    = spps_pkg::MUL_W;
    localparam int EXT_W = (COUNT_WIDTH > 39) ? COUNT_WIDTH + 1 : 40;
    localparam logic [EXT_W-1:0] CNT_CLAMP = {{(EXT_W-39){1'b0}}, 1'b1, 38'b0};

    typedef enum logic [16:0] {
        ST_IDLE    = 17'b0_0000_0000_0000_0001,
        ST_POS_LO  = 17'b0_0000_0000_0000_0010,
        ST_POS_HI  = 17'b0_0000_0000_0000_0100,
        ST_POS_SUM = 17'b0_0000_0000_0000_1000,
        ST_ERR     = 17'b0_0000_0000_0001_0000,
        ST_ABS     = 17'b0_0000_0000_0010_0000,
        ST_DECIDE  = 17'b0_0000_0000_0100_0000,
        ST_MAG_LO  = 17'b0_0000_0000_1000_0000,
        ST_MAG_HI  = 17'b0_0000_0001_0000_0000,
        ST_MAG_SUM = 17'b0_0000_0010_0000_0000,
        ST_CTL     = 17'b0_0000_0100_0000_0000,
        ST_PER_LO  = 17'b0_0000_1000_0000_0000,
        ST_PER_HI  = 17'b0_0001_0000_0000_0000,
        ST_PER_SUM = 17'b0_0010_0000_0000_0000,
        ST_PER_Q   = 17'b0_0100_0000_0000_0000,
        ST_PER_DIV = 17'b0_1000_0000_0000_0000,
        ST_FIN     = 17'b1_0000_0000_0000_0000
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0] kp_reg, tol_reg, min_per_reg, max_per_reg;
    logic [23:0] dps_reg, home_reg;

    // control state
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [23:0]            target_reg;
    logic                   enabled_reg;
    logic                   dir_reg;

    // working registers
    logic                   post_reg;
    logic [2*MW-1:0]        acc_reg;
    logic [62:0]            sum_reg;
    logic [62:0]            posq_reg;
    logic signed [63:0]     err_reg;
    logic [62:0]            eabs_reg;
    logic                   epos_reg;
    logic                   at_reg;
    logic [spps_pkg::CTL_W-1:0] ctl_reg;
    logic [15:0]            diff_reg;
    logic                   flat_reg;
    logic                   pulse_reg;
    logic [15:0]            period_reg;

    // output register
    logic                   m_valid_reg;
    logic                   m_pulse_reg, m_dir_reg, m_en_reg, m_at_reg;
    logic [15:0]            m_period_reg;
    logic [31:0]            m_pos_reg;
    logic [23:0]            m_ang_reg;

    // shared multiplier
    logic [MW-1:0]          mul_a, mul_b;
    logic [2*MW-1:0]        product;

    // combinational helpers
    logic [EXT_W-1:0]             cnt_ext;
    logic                         cnt_neg;
    logic [EXT_W-1:0]             cnt_abs;
    logic [spps_pkg::CMAG_W-1:0]  cmag;
    logic [spps_pkg::EMAG_W-1:0]  emag;
    logic signed [63:0]           t256;
    logic signed [63:0]           pm;
    logic [MW-1:0]                per_x;
    logic [54:0]                  pq;
    logic [23:0]                  ang;
    logic                         out_free;

    spps_mul u_mul (
        .aclk    (aclk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        cnt_ext = {{(EXT_W-COUNT_WIDTH){cnt_reg[COUNT_WIDTH-1]}}, cnt_reg};
        cnt_neg = cnt_reg[COUNT_WIDTH-1];
        cnt_abs = cnt_neg ? (~cnt_ext + EXT_W'(1)) : cnt_ext;
        cmag    = (cnt_abs > CNT_CLAMP) ? CNT_CLAMP[spps_pkg::CMAG_W-1:0]
                                        : cnt_abs[spps_pkg::CMAG_W-1:0];
        emag    = (eabs_reg > spps_pkg::ERR_CLAMP)
                  ? spps_pkg::ERR_CLAMP[spps_pkg::EMAG_W-1:0]
                  : eabs_reg[spps_pkg::EMAG_W-1:0];
        t256    = {{32{target_reg[23]}}, target_reg, 8'b0};
        pm      = {1'b0, sum_reg};
        // ceil of num / 2^24, then plus 99 ahead of the divide by 100
        per_x   = MW'(sum_reg[46:24]) + MW'(|sum_reg[23:0]) + spps_pkg::HUNDRED_M1;
        pq      = posq_reg[62:8];
        if (!cnt_neg) begin
            ang = (pq > 55'd8388607) ? 24'h7FFFFF : pq[23:0];
        end else begin
            ang = (pq > 55'd8388608) ? 24'h800000 : (~pq[23:0] + 24'd1);
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_POS_LO: begin
                mul_a = cmag[MW-1:0];
                mul_b = dps_reg;
            end
            ST_POS_HI: begin
                mul_a = MW'(cmag[spps_pkg::CMAG_W-1:MW]);
                mul_b = dps_reg;
            end
            ST_MAG_LO: begin
                mul_a = emag[MW-1:0];
                mul_b = MW'(kp_reg);
            end
            ST_MAG_HI: begin
                mul_a = MW'(emag[spps_pkg::EMAG_W-1:MW]);
                mul_b = MW'(kp_reg);
            end
            ST_PER_LO: begin
                mul_a = ctl_reg[MW-1:0];
                mul_b = MW'(diff_reg);
            end
            ST_PER_HI: begin
                mul_a = MW'(ctl_reg[spps_pkg::CTL_W-1:MW]);
                mul_b = MW'(diff_reg);
            end
            ST_PER_Q: begin
                mul_a = per_x;
                mul_b = spps_pkg::RECIP;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg      <= spps_pkg::KP_GAIN_RST;
            tol_reg     <= spps_pkg::TOLERANCE_RST;
            min_per_reg <= spps_pkg::MIN_PER_RST;
            max_per_reg <= spps_pkg::MAX_PER_RST;
            dps_reg     <= spps_pkg::DEG_STEP_RST;
            home_reg    <= spps_pkg::HOME_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                spps_pkg::REG_KP_GAIN:   kp_reg      <= cfg_data[15:0];
                spps_pkg::REG_TOLERANCE: tol_reg     <= cfg_data[15:0];
                spps_pkg::REG_MIN_PER:   min_per_reg <= cfg_data[15:0];
                spps_pkg::REG_MAX_PER:   max_per_reg <= cfg_data[15:0];
                spps_pkg::REG_DEG_STEP:  dps_reg     <= cfg_data;
                spps_pkg::REG_HOME:      home_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            target_reg  <= '0;
            enabled_reg <= 1'b1;
            dir_reg     <= 1'b1;
            post_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // ST_FIN reloads the result register itself
            if (m_valid_reg && m_ready && (state_reg != ST_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        pulse_reg  <= 1'b0;
                        period_reg <= '0;
                        post_reg   <= 1'b1;
                        state_reg  <= ST_POS_LO;
                        case (spps_pkg::kind_t'(s_kind))
                            spps_pkg::KIND_TICK: post_reg <= 1'b0;
                            spps_pkg::KIND_TARGET: begin
                                target_reg  <= s_target_angle;
                                enabled_reg <= 1'b1;
                            end
                            spps_pkg::KIND_HOME: begin
                                cnt_reg    <= '0;
                                target_reg <= home_reg;
                            end
                            spps_pkg::KIND_ENABLE: enabled_reg <= s_enable_value;
                            default: post_reg <= 1'b0;
                        endcase
                    end
                end
                ST_POS_LO:  state_reg <= ST_POS_HI;
                ST_POS_HI: begin
                    acc_reg   <= product;
                    state_reg <= ST_POS_SUM;
                end
                ST_POS_SUM: begin
                    sum_reg   <= 63'(acc_reg) + {product[38:0], 24'b0};
                    state_reg <= ST_ERR;
                end
                ST_ERR: begin
                    err_reg   <= cnt_neg ? (t256 + pm) : (t256 - pm);
                    // bias a negative magnitude so the shift rounds toward minus infinity
                    posq_reg  <= cnt_neg ? (sum_reg + 63'd255) : sum_reg;
                    state_reg <= ST_ABS;
                end
                ST_ABS: begin
                    eabs_reg  <= err_reg[63] ? 63'(-err_reg) : err_reg[62:0];
                    epos_reg  <= !err_reg[63] && (err_reg != 64'sd0);
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    at_reg <= (eabs_reg <= {39'b0, tol_reg, 8'b0});
                    if (post_reg || !enabled_reg || (eabs_reg <= {39'b0, tol_reg, 8'b0})) begin
                        state_reg <= ST_FIN;
                    end else begin
                        state_reg <= ST_MAG_LO;
                    end
                end
                ST_MAG_LO:  state_reg <= ST_MAG_HI;
                ST_MAG_HI: begin
                    acc_reg   <= product;
                    state_reg <= ST_MAG_SUM;
                end
                ST_MAG_SUM: begin
                    sum_reg   <= 63'(acc_reg) + 63'({product[32:0], 24'b0});
                    state_reg <= ST_CTL;
                end
                ST_CTL: begin
                    ctl_reg   <= (sum_reg > spps_pkg::FULL_CONTROL)
                                 ? spps_pkg::FULL_CONTROL[spps_pkg::CTL_W-1:0]
                                 : sum_reg[spps_pkg::CTL_W-1:0];
                    dir_reg   <= epos_reg && (sum_reg != 63'd0);
                    diff_reg  <= max_per_reg - min_per_reg;
                    flat_reg  <= (max_per_reg <= min_per_reg);
                    state_reg <= ST_PER_LO;
                end
                ST_PER_LO:  state_reg <= ST_PER_HI;
                ST_PER_HI: begin
                    acc_reg   <= product;
                    state_reg <= ST_PER_SUM;
                end
                ST_PER_SUM: begin
                    sum_reg   <= 63'(acc_reg) + 63'({product[22:0], 24'b0});
                    state_reg <= ST_PER_Q;
                end
                ST_PER_Q:   state_reg <= ST_PER_DIV;
                ST_PER_DIV: begin
                    period_reg <= flat_reg ? max_per_reg
                                  : (max_per_reg
                                     - product[spps_pkg::RECIP_SHIFT+15:spps_pkg::RECIP_SHIFT]);
                    pulse_reg  <= 1'b1;
                    cnt_reg    <= dir_reg ? (cnt_reg + COUNT_WIDTH'(1))
                                          : (cnt_reg - COUNT_WIDTH'(1));
                    // recompute position and error for the new count
                    post_reg   <= 1'b1;
                    state_reg  <= ST_POS_LO;
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_pulse_reg  <= pulse_reg;
                        m_dir_reg    <= dir_reg;
                        m_period_reg <= period_reg;
                        m_en_reg     <= enabled_reg ^ spps_pkg::ENABLE_ACTIVE_LOW;
                        m_pos_reg    <= cnt_ext[31:0];
                        m_ang_reg    <= ang;
                        m_at_reg     <= at_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_step_pulse         = m_pulse_reg;
    assign m_direction_positive = m_dir_reg;
    assign m_pulse_interval_us  = m_period_reg;
    assign m_enable_pin         = m_en_reg;
    assign m_step_position      = m_pos_reg;
    assign m_position_angle     = m_ang_reg;
    assign m_at_target          = m_at_reg;

endmodule
`default_nettype wire
